/* rtl/core/sample_voice_mixer_with_fade_defines.svh */
// ----------------------------------------------------------------------------
// Sample voice mixer assertion macros
// Shared concurrent assertion shorthands. Synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_VOICE_MIXER_WITH_FADE_DEFINES_SVH
`define SAMPLE_VOICE_MIXER_WITH_FADE_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define SVM_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SVM_ASSERT_NOW(lbl, clk, rst_n, expr, msg)
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/svm_pkg.sv */
// ----------------------------------------------------------------------------
// Sample voice mixer package
// Opcodes, field widths, defaults and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package svm_pkg;

  // Defaults for the top level parameters.
  localparam int DEF_VOICES       = 8;
  localparam int DEF_SAMPLE_WORDS = 16384;

  // Field widths.
  localparam int OP_W    = 3;
  localparam int VOICE_W = 3;
  localparam int ADDR_W  = 14;
  localparam int LEN_W   = 15;
  localparam int NOTE_W  = 7;
  localparam int WORD_W  = 16;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 24;

  // Fixed widths of the command fields (large enough for the parameter ranges).
  localparam int VIDX_W = 6;
  localparam int STEP_W = 5;
  localparam int CNT_W  = 7;

  // Mix accumulator: up to 64 words of at most 2^15 magnitude.
  localparam int ACC_W = 24;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd4;
  localparam logic [OP_W-1:0] OP_MIX   = 3'd5;

  // Fade constants.
  localparam logic signed [3:0]  FADE_RELOAD = 4'sd4;
  localparam logic signed [3:0]  FADE_SAT    = -4'sd1;
  localparam logic signed [15:0] FADE_LIMIT  = 16'sd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              mod_step;
    logic              mem_write;
    logic              start;
    logic              use_v;
    logic              stop_chk;
    logic              stop_set;
    logic              proc;
    logic              acc;
    logic              scan;
    logic              scan_fin;
    logic              out_load;
    logic [VIDX_W-1:0] idx_a;
    logic [VIDX_W-1:0] idx_b;
    logic [STEP_W-1:0] step;
  } svm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop_fetch;
    logic out_free;
  } svm_status_t;

endpackage

`default_nettype wire

/* rtl/core/svm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/svm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sample voice mixer controller
// Sequences each operation through address reduction, voice scans and mixing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sample_voice_mixer_with_fade_defines.svh"

module svm_ctrl import svm_pkg::*; #(
  parameter int VOICES    = DEF_VOICES,
  parameter int MOD_STEPS = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [OP_W-1:0] in_opcode,
  input  wire svm_status_t     status,
  output svm_cmd_t             cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_START = 4'd3;
  localparam logic [3:0] S_STOP0 = 4'd4;
  localparam logic [3:0] S_STOP1 = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_SCANF = 4'd7;
  localparam logic [3:0] S_MIX   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          op_nxt   = in_opcode;
          cnt_nxt  = '0;
          priority case (in_opcode)
            OP_WRITE, OP_START: begin
              state_nxt = S_MOD;
              cnt_nxt   = CNT_W'(MOD_STEPS - 1);
            end
            OP_STOP:           state_nxt = S_STOP0;
            OP_ALLOC, OP_FIND: state_nxt = S_SCAN;
            OP_MIX:            state_nxt = S_MIX;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cmd.step     = STEP_W'(cnt_r);
        if (cnt_r == '0) begin
          state_nxt = (op_r == OP_WRITE) ? S_WRITE : S_START;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt     = S_DONE;
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_DONE;
      end
      S_STOP0: begin
        cmd.use_v    = 1'b1;
        cmd.stop_chk = 1'b1;
        state_nxt    = status.stop_fetch ? S_STOP1 : S_DONE;
      end
      S_STOP1: begin
        cmd.use_v    = 1'b1;
        cmd.proc     = 1'b1;
        cmd.stop_set = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.idx_a = VIDX_W'(cnt_r);
        if (cnt_r == CNT_W'(VOICES - 1)) begin
          state_nxt = S_SCANF;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCANF: begin
        cmd.scan_fin = 1'b1;
        state_nxt    = S_DONE;
      end
      S_MIX: begin
        // Read voice cnt, process voice cnt-1, accumulate voice cnt-2.
        cmd.idx_a = VIDX_W'(cnt_r);
        cmd.idx_b = VIDX_W'(cnt_r - 1'b1);
        cmd.proc  = (cnt_r != '0) && (cnt_r <= CNT_W'(VOICES));
        cmd.acc   = (cnt_r >= CNT_W'(2));
        if (cnt_r == CNT_W'(VOICES + 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
  end

  `SVM_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, state_r != S_IDLE, "accepted transfer left controller idle")
  `SVM_ASSERT_NEXT(a_done_waits, clk, rst_n, (state_r == S_DONE) && !status.out_free, state_r == S_DONE, "result dropped while output stalled")
  `SVM_ASSERT_NEXT(a_load_to_idle, clk, rst_n, cmd.out_load, state_r == S_IDLE, "controller not idle after result load")
  `SVM_ASSERT_NOW(a_one_action, clk, rst_n, $onehot0({cmd.mem_write, cmd.start, cmd.scan, cmd.out_load, cmd.mod_step}), "conflicting commands")

endmodule

`default_nettype wire

/* rtl/core/svm_datapath.sv */
// ----------------------------------------------------------------------------
// Sample voice mixer datapath
// Voice state, sample memory, fetch and fade logic, mix accumulator, result.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_datapath import svm_pkg::*; #(
  parameter int VOICES       = DEF_VOICES,
  parameter int SAMPLE_WORDS = DEF_SAMPLE_WORDS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [IN_W-1:0] in_tdata,
  input  wire svm_cmd_t        cmd,
  output svm_status_t          status,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OUT_W-1:0]     out_tdata
);

  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int VIW   = $clog2(VOICES);
  localparam int DIV_D = VOICES / 2;
  localparam int DIV_S = 17 + $clog2(DIV_D);
  localparam longint DIV_M = ((longint'(1) << DIV_S) + DIV_D - 1) / DIV_D;
  localparam logic [18:0] DIV_MUL = 19'(DIV_M);

  // Captured operation.
  logic [OP_W-1:0]    op_r;
  logic [VOICE_W-1:0] v_r;
  logic [ADDR_W-1:0]  rem_r;
  logic [LEN_W-1:0]   len_in_r;
  logic [NOTE_W-1:0]  note_in_r;
  logic [WORD_W-1:0]  word_r;

  // Voice state.
  logic                     playing_r [VOICES];
  logic signed [WORD_W-1:0] fade_r    [VOICES];
  logic [LEN_W-1:0]         pos_r     [VOICES];
  logic [LEN_W-1:0]         len_r     [VOICES];
  logic [AW-1:0]            base_r    [VOICES];
  logic [AW-1:0]            cur_r     [VOICES];
  logic [NOTE_W-1:0]        note_r    [VOICES];
  logic signed [3:0]        ft_r;

  // Scan, mix and result registers.
  logic                     hit_a_r, hit_b_r;
  logic [VIW-1:0]           idx_a_r, idx_b_r;
  logic signed [WORD_W-1:0] yield_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_data_r;

  logic            v_ok;
  logic [VIW-1:0]  vi, ia, ib;
  logic [WORD_W-1:0] rd_data;

  assign v_ok = ({{(32 - VOICE_W){1'b0}}, v_r} < 32'(VOICES));
  assign vi   = VIW'(v_r);
  assign ia   = cmd.use_v ? vi : VIW'(cmd.idx_a);
  assign ib   = cmd.use_v ? vi : VIW'(cmd.idx_b);

  // Sample memory.
  svm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SAMPLE_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.mem_write),
    .waddr(AW'(rem_r)),
    .wdata(word_r),
    .raddr(cur_r[ia]),
    .rdata(rd_data)
  );

  // One word fetch for voice ib, using the memory word read in the cycle before.
  logic                     f_play;
  logic signed [WORD_W-1:0] f_fade, f_yield, fd, fh;
  logic [LEN_W-1:0]         f_pos, pos1;
  logic [AW-1:0]            f_cur;
  logic signed [3:0]        f_ft, ft_dec;

  always_comb begin
    fd      = fade_r[ib];
    f_play  = playing_r[ib];
    f_fade  = fd;
    f_pos   = pos_r[ib];
    f_cur   = cur_r[ib];
    f_ft    = ft_r;
    f_yield = '0;
    ft_dec  = (ft_r == FADE_SAT) ? FADE_SAT : ft_r - 4'sd1;
    fh      = fd;
    pos1    = pos_r[ib] + 1'b1;
    if (playing_r[ib]) begin
      f_ft = ft_dec;
      if (fd != '0) begin
        // Fading: halve toward zero when the shared tick runs out.
        if (ft_dec < 0) begin
          fh   = (fd >>> 1) + ((fd[WORD_W-1] & fd[0]) ? 16'sd1 : 16'sd0);
          f_ft = FADE_RELOAD;
        end
        if ((fh < FADE_LIMIT) && (fh > -FADE_LIMIT)) begin
          f_fade = '0;
          f_play = 1'b0;
        end else begin
          f_fade  = fh;
          f_yield = fh;
        end
      end else begin
        // Playing from memory; the last word becomes the fade value.
        f_yield = rd_data;
        if (pos1 >= len_r[ib]) begin
          f_fade = rd_data;
          f_pos  = '0;
          f_cur  = base_r[ib];
        end else begin
          f_pos = pos1;
          f_cur = (cur_r[ib] == AW'(SAMPLE_WORDS - 1)) ? '0 : cur_r[ib] + 1'b1;
        end
      end
    end
  end

  // Division of a word by VOICES/2 toward zero through a reciprocal multiply.
  logic signed [16:0] ys;
  logic [16:0]        mag, q;
  logic [35:0]        prod;
  logic signed [ACC_W-1:0] q_s;

  always_comb begin
    ys   = {yield_r[WORD_W-1], yield_r};
    mag  = ys[16] ? 17'(17'sd0 - ys) : 17'(ys);
    prod = 36'(mag) * 36'(DIV_MUL);
    q    = 17'(prod >> DIV_S);
    q_s  = ys[16] ? -ACC_W'(q) : ACC_W'(q);
  end

  // Address reduction step.
  logic [39:0] mod_sub;
  assign mod_sub = 40'(SAMPLE_WORDS) << cmd.step;

  // Saturated mix and result word.
  logic signed [WORD_W-1:0] mix_sat;
  always_comb begin
    priority if (acc_r > ACC_W'(32767)) begin
      mix_sat = 16'sh7fff;
    end else if (acc_r < -ACC_W'(32768)) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = WORD_W'(acc_r);
    end
  end

  assign status.stop_fetch = v_ok && playing_r[vi] && (fade_r[vi] == '0);
  assign status.out_free   = !out_valid_r || out_tready;
  assign out_tvalid        = out_valid_r;
  assign out_tdata         = out_data_r;

  // Operation capture, address reduction, scan and mix registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tdata[2:0];
      v_r       <= in_tdata[5:3];
      rem_r     <= in_tdata[19:6];
      len_in_r  <= in_tdata[34:20];
      note_in_r <= in_tdata[41:35];
      word_r    <= in_tdata[57:42];
      hit_a_r   <= 1'b0;
      hit_b_r   <= 1'b0;
      idx_a_r   <= '0;
      idx_b_r   <= '0;
      acc_r     <= '0;
    end
    if (cmd.mod_step && (40'(rem_r) >= mod_sub)) begin
      rem_r <= ADDR_W'(40'(rem_r) - mod_sub);
    end
    // Scan: first idle or matching voice, and first fading voice.
    if (cmd.scan) begin
      if (!hit_a_r && ((op_r == OP_ALLOC) ? !playing_r[ia]
          : (playing_r[ia] && (note_r[ia] == note_in_r)))) begin
        hit_a_r <= 1'b1;
        idx_a_r <= ia;
      end
      if (!hit_b_r && (fade_r[ia] != '0)) begin
        hit_b_r <= 1'b1;
        idx_b_r <= ia;
      end
    end
    if (cmd.proc) begin
      yield_r <= f_yield;
    end
    if (cmd.acc) begin
      acc_r <= acc_r + q_s;
    end
  end

  // Voice state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        playing_r[i] <= 1'b0;
        fade_r[i]    <= '0;
      end
      ft_r <= '0;
    end else begin
      if (cmd.start && v_ok && (len_in_r != '0)) begin
        pos_r[vi]     <= '0;
        base_r[vi]    <= AW'(rem_r);
        cur_r[vi]     <= AW'(rem_r);
        len_r[vi]     <= len_in_r;
        note_r[vi]    <= note_in_r;
        playing_r[vi] <= 1'b1;
        fade_r[vi]    <= '0;
      end
      if (cmd.stop_chk && v_ok && playing_r[vi] && (fade_r[vi] != '0)) begin
        playing_r[vi] <= 1'b0;
      end
      if (cmd.proc) begin
        playing_r[ib] <= f_play;
        fade_r[ib]    <= cmd.stop_set ? f_yield : f_fade;
        pos_r[ib]     <= f_pos;
        cur_r[ib]     <= f_cur;
        ft_r          <= f_ft;
      end
      if (cmd.scan_fin && (op_r == OP_ALLOC) && !hit_a_r && hit_b_r) begin
        fade_r[idx_b_r]    <= '0;
        playing_r[idx_b_r] <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data_r <= '0;
      if (op_r == OP_MIX) begin
        out_data_r[15:0] <= mix_sat;
      end
      if ((op_r == OP_ALLOC) || (op_r == OP_FIND)) begin
        if (hit_a_r) begin
          out_data_r[18:16] <= 3'(idx_a_r);
          out_data_r[19]    <= 1'b1;
        end else if ((op_r == OP_ALLOC) && hit_b_r) begin
          out_data_r[18:16] <= 3'(idx_b_r);
          out_data_r[19]    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sample_voice_mixer_with_fade.sv */
// ----------------------------------------------------------------------------
// Sample voice mixer with fade
// Multi-voice sample player: sample memory writes, voice start, stop,
// allocation and lookup, and a saturated mix of all voices per mix tick.
//
// Channel  Direction  Carries
// in_      slave      one command: opcode, voice, address, length, note, word
// out_     master     one result per command: mix, voice index, found flag
//
// Write and start first run 15 - log2(SAMPLE_WORDS), at least 1, address
// reduction steps. Stop fetches a fade word only when the voice plays and
// is not yet fading; allocate and find scan every voice, a mix tick takes
// one voice a cycle through the single sample memory read port, the fetch
// logic and the divider, and an unused opcode goes straight to its result.
// One command is worked on at a time; a new command is taken while the last
// result still waits in the output register, and a stalled output holds the
// controller until the register is free.
// Reset (rst_n low, synchronous) stops every voice and clears the fade tick.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_voice_mixer_with_fade import svm_pkg::*; #(
  parameter int VOICES       = DEF_VOICES,
  parameter int SAMPLE_WORDS = DEF_SAMPLE_WORDS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // opcode[2:0] voice[5:3] address[19:6] sample_length[34:20] note[41:35]
  // write_word[57:42], zero fill above
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // mixed_sample[15:0] voice_index[18:16] found[19], zero fill above
  output logic      [OUT_W-1:0] out_tdata
);

  localparam int AW        = $clog2(SAMPLE_WORDS);
  localparam int MOD_STEPS = (AW > ADDR_W) ? 1 : ADDR_W - AW + 1;

  svm_cmd_t    cmd;
  svm_status_t status;

  svm_ctrl #(
    .VOICES   (VOICES),
    .MOD_STEPS(MOD_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_opcode(in_tdata[OP_W-1:0]),
    .status   (status),
    .cmd      (cmd)
  );

  svm_datapath #(
    .VOICES      (VOICES),
    .SAMPLE_WORDS(SAMPLE_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

/* tb/sv/sample_voice_mixer_with_fade_test.sv */
// ----------------------------------------------------------------------------
// Sample voice mixer regression bench
// Sends directed and random commands into the mixer and checks every result
// against a hand-typed value or a cycle-free model of voices, fade and memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_voice_mixer_with_fade_test import svm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = DEF_VOICES;
  localparam int NW = DEF_SAMPLE_WORDS;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 600;

  // Opcodes without an operation.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VOICE_W-1:0] voice;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [NOTE_W-1:0]  note;
    logic [WORD_W-1:0]  word;
  } command_t;

  typedef struct packed {
    logic [WORD_W-1:0] mix;
    logic [2:0]        vidx;
    logic              hit;
  } reply_t;

  // One row of stimulus; has_exp marks a hand-typed result.
  typedef struct {
    command_t cmd;
    bit       has_exp;
    reply_t   exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // Mirror of the block's state.
  logic signed [15:0] mem_m [NW];
  bit                 written [NW];
  bit                 playing [NV];
  logic signed [15:0] fade [NV];
  int unsigned        pos [NV], base [NV], vlen [NV], vnote [NV];
  int                 fade_tick;

  reply_t pending_replies [$];
  row_t cmd_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  int sent = 0;
  int total_cmds = 0;
  bit stall_long = 0;
  bit send_done = 0;

  sample_voice_mixer_with_fade dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [IN_W-1:0] pack_cmd(command_t c);
    return {6'd0, c.word, c.note, c.len, c.addr, c.voice, c.op};
  endfunction

  // Next word of one voice, with the shared fade counter.
  function automatic logic signed [15:0] voice_word(int v);
    logic signed [15:0] w;
    if (!playing[v]) return 0;
    if (fade_tick > -1) fade_tick--;
    if (fade[v] != 0) begin
      if (fade_tick < 0) begin
        fade[v] = fade[v] / 2;
        fade_tick = 4;
      end
      if (fade[v] < 6 && fade[v] > -6) begin
        fade[v] = 0;
        playing[v] = 0;
        return 0;
      end
      return fade[v];
    end
    w = mem_m[(base[v] + pos[v]) % NW];
    pos[v]++;
    if (pos[v] >= vlen[v]) begin
      fade[v] = w;
      pos[v] = 0;
    end
    return w;
  endfunction

  function automatic reply_t mixer_predict(command_t c);
    reply_t r;
    int acc;
    r = '0;
    acc = 0;
    case (c.op)
      OP_WRITE: begin
        mem_m[c.addr] = c.word;
        written[c.addr] = 1;
      end
      OP_START: if (c.len != 0) begin
        pos[c.voice] = 0;
        base[c.voice] = c.addr;
        vlen[c.voice] = c.len;
        vnote[c.voice] = c.note;
        playing[c.voice] = 1;
        fade[c.voice] = 0;
      end
      OP_STOP: if (playing[c.voice]) begin
        if (fade[c.voice] == 0) fade[c.voice] = voice_word(c.voice);
        else playing[c.voice] = 0;
      end
      OP_ALLOC: begin
        for (int i = 0; i < NV && !r.hit; i++)
          if (!playing[i]) begin r.vidx = 3'(i); r.hit = 1; end
        for (int i = 0; i < NV && !r.hit; i++)
          if (fade[i] != 0) begin
            fade[i] = 0;
            playing[i] = 0;
            r.vidx = 3'(i);
            r.hit = 1;
          end
      end
      OP_FIND:
        for (int i = 0; i < NV && !r.hit; i++)
          if (playing[i] && vnote[i] == c.note) begin r.vidx = 3'(i); r.hit = 1; end
      OP_MIX: begin
        for (int i = 0; i < NV; i++) acc += int'(voice_word(i)) / (NV / 2);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        r.mix = acc[15:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Only memory that has been written may be played.
  function automatic bit span_written(int a, int n);
    for (int k = 0; k < n; k++) if (!written[(a + k) % NW]) return 0;
    return 1;
  endfunction

  // Random command; starts only over written spans, mostly short samples.
  function automatic command_t random_cmd();
    command_t c;
    int sel;
    c.voice = VOICE_W'($urandom_range(0, 7));
    c.addr  = ADDR_W'($urandom);
    c.len   = LEN_W'($urandom_range(1, 12));
    c.note  = NOTE_W'($urandom_range(0, 127) & ($urandom_range(0, 1) ? 127 : 7));
    c.word  = WORD_W'($urandom);
    c.op    = OP_MIX;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      c.op = OP_WRITE;
      c.addr = $urandom_range(0, 1) ? ADDR_W'($urandom_range(0, 63)) : ADDR_W'($urandom);
    end else if (sel < 38) begin
      c.op = OP_START;
      c.addr = ADDR_W'($urandom_range(0, 63));
      if ($urandom_range(0, 9) == 0) c.len = '0;
      if (!span_written(int'(c.addr), int'(c.len))) c.op = OP_MIX;
    end else if (sel < 46) c.op = OP_STOP;
    else if (sel < 54) c.op = OP_ALLOC;
    else if (sel < 62) c.op = OP_FIND;
    else if (sel < 97) c.op = OP_MIX;
    else c.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    return c;
  endfunction

  // Sender: offers commands with random gaps.
  initial begin
    row_t rw;
    reply_t want;
    int gap;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (cmd_queue.size() > 0 || !send_done) begin
      if (cmd_queue.size() == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        continue;
      end
      rw = cmd_queue.pop_front();
      gap = stall_long ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15));
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= pack_cmd(rw.cmd);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      want = mixer_predict(rw.cmd);
      pending_replies.push_back(rw.has_exp ? rw.exp : want);
      sent++;
    end
    in_tvalid <= 1'b0;
  end

  // Receiver: random stalls, and one long hold-off to back the block up.
  initial begin
    int wait_n;
    repeat (8) @(posedge clk);
    forever begin
      if (stall_long) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_long = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.mix  = out_tdata[15:0];
      got.vidx = out_tdata[18:16];
      got.hit  = out_tdata[19];
      if (pending_replies.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = pending_replies.pop_front();
        if (got.mix != want.mix)
          report_mismatch("mixed_sample", $signed(got.mix), $signed(want.mix));
        if (got.vidx != want.vidx) report_mismatch("voice_index", got.vidx, want.vidx);
        if (got.hit != want.hit) report_mismatch("found", got.hit, want.hit);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sample_voice_mixer_with_fade regression: fail");
      $finish;
    end
  end

  // Directed table, then random stimulus, then the drain.
  initial begin
    row_t rows [$];
    row_t r;
    for (int i = 0; i < NV; i++) begin
      playing[i] = 0; fade[i] = 0; pos[i] = 0; base[i] = 0; vlen[i] = 0; vnote[i] = 0;
    end
    for (int i = 0; i < NW; i++) begin mem_m[i] = 0; written[i] = 0; end
    fade_tick = 0;

    // Fresh block: mix is silent, allocate gives voice zero, find misses.
    r.has_exp = 1; r.exp = '0;
    r.cmd = '{OP_MIX, 3'd0, 14'd0, 15'd0, 7'd0, 16'd0};      rows.push_back(r);
    r.exp = '{16'd0, 3'd0, 1'b1};
    r.cmd = '{OP_ALLOC, 3'd0, 14'd0, 15'd0, 7'd0, 16'd0};    rows.push_back(r);
    r.exp = '0;
    r.cmd = '{OP_FIND, 3'd0, 14'd0, 15'd0, 7'h7f, 16'd0};    rows.push_back(r);
    r.cmd = '{OP_WRITE, 3'd7, 14'h3fff, 15'h7fff, 7'h7f, 16'h8000}; rows.push_back(r);
    r.cmd = '{OP_WRITE, 3'd0, 14'd0, 15'd0, 7'd0, 16'h7fff}; rows.push_back(r);
    r.cmd = '{OP_SPARE6, 3'd0, 14'd0, 15'd0, 7'd0, 16'd0};   rows.push_back(r);
    r.cmd = '{OP_SPARE7, 3'd7, 14'h3fff, 15'h7fff, 7'h7f, 16'hffff}; rows.push_back(r);
    r.has_exp = 0;
    r.cmd = '{OP_WRITE, 3'd0, 14'd1, 15'd0, 7'd0, 16'd0};    rows.push_back(r);
    r.cmd = '{OP_WRITE, 3'd0, 14'd2, 15'd0, 7'd0, 16'hfffb}; rows.push_back(r);
    // Wrap around the top of memory, and a start with zero length.
    r.cmd = '{OP_START, 3'd7, 14'h3fff, 15'd2, 7'h7f, 16'd0}; rows.push_back(r);
    r.cmd = '{OP_START, 3'd1, 14'd0, 15'd0, 7'd3, 16'd0};    rows.push_back(r);
    r.cmd = '{OP_START, 3'd0, 14'd0, 15'd1, 7'd9, 16'd0};    rows.push_back(r);
    r.cmd = '{OP_START, 3'd2, 14'd1, 15'd1, 7'd9, 16'd0};    rows.push_back(r);
    r.cmd = '{OP_FIND, 3'd0, 14'd0, 15'd0, 7'd9, 16'd0};     rows.push_back(r);
    for (int k = 0; k < 8; k++) begin
      r.cmd = '{OP_MIX, 3'd0, 14'd0, 15'd0, 7'd0, 16'd0};    rows.push_back(r);
    end
    r.cmd = '{OP_STOP, 3'd7, 14'd0, 15'd0, 7'd0, 16'd0};     rows.push_back(r);
    r.cmd = '{OP_STOP, 3'd2, 14'd0, 15'd0, 7'd0, 16'd0};     rows.push_back(r);
    r.cmd = '{OP_STOP, 3'd5, 14'd0, 15'd0, 7'd0, 16'd0};     rows.push_back(r);

    // Walk the table; hand-typed rows are checked against their own value.
    foreach (rows[i]) cmd_queue.push_back(rows[i]);
    // Random commands, drawn as the sender takes them so that the written
    // map is current; the long hold-off falls in the middle.
    r.has_exp = 0;
    r.exp = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      wait (cmd_queue.size() == 0);
      if (n == N_RANDOM / 2) stall_long = 1;
      r.cmd = random_cmd();
      cmd_queue.push_back(r);
    end
    total_cmds = rows.size() + N_RANDOM;
    send_done = 1;
    wait (sent == total_cmds && pending_replies.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("sample_voice_mixer_with_fade regression: pass");
    else $display("sample_voice_mixer_with_fade regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
